/* rtl/threshold_window_trigger_core_defines.svh */
// Assertion macros shared by the threshold window trigger RTL.
`ifndef THRESHOLD_WINDOW_TRIGGER_CORE_DEFINES_SVH
`define THRESHOLD_WINDOW_TRIGGER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define TWT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside of reset.
`define TWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/twt_pkg.sv */
// Package with types, codes and default sizes for the threshold window trigger.
package twt_pkg;

  // Default widths of the sample and the timestamp.
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_DEF  = 32;

  // Configuration port sizes and fixed register widths.
  localparam int CFG_DATA_WIDTH   = 32;
  localparam int CFG_INDEX_WIDTH  = 3;
  localparam int MARGIN_WIDTH     = 31;
  localparam int HOLD_OFF_WIDTH   = 32;
  localparam int STATE_WIDTH      = 2;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_MODE       = 3'd0,
    CFG_LIMIT_LOW  = 3'd1,
    CFG_LIMIT_HIGH = 3'd2,
    CFG_MARGIN     = 3'd3,
    CFG_HOLD_OFF   = 3'd4
  } cfg_index_e;

  // Comparison modes.
  typedef enum logic [1:0] {
    MODE_BELOW   = 2'd0,
    MODE_ABOVE   = 2'd1,
    MODE_INSIDE  = 2'd2,
    MODE_OUTSIDE = 2'd3
  } mode_e;

  // Trigger states as seen on the result item.
  typedef enum logic [STATE_WIDTH-1:0] {
    ST_DISABLED = 2'd0,
    ST_IDLE     = 2'd1,
    ST_TRIG     = 2'd2
  } trig_state_e;

endpackage

/* rtl/threshold_window_trigger_core.sv */
// Window comparator with hysteresis and hold-off, one result item per input item.
// Path: input register, one level of compare logic, result register; each loads when free.
// Throughput: one item per cycle while the result side is not stalled.
// The input side keeps taking items while a result waits, as long as the result register frees.
// Reset clears the state to disabled, drops any hold-off, zeroes config and valid flags.
// Configuration writes are registered and are accepted in every cycle.
`include "threshold_window_trigger_core_defines.svh"

module threshold_window_trigger_core #(
  parameter int VALUE_WIDTH = twt_pkg::VALUE_WIDTH_DEF,
  parameter int TIME_WIDTH  = twt_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [twt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [twt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i,
  // Input item channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0]       sample_i,
  input  logic [TIME_WIDTH-1:0]               time_ms_i,
  // Result item channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [twt_pkg::STATE_WIDTH-1:0]     trigger_state_o,
  output logic                                changed_o
);
  import twt_pkg::*;

  localparam int CfgExtW = (VALUE_WIDTH > CFG_DATA_WIDTH) ? VALUE_WIDTH : CFG_DATA_WIDTH;
  localparam int BaseW   = (VALUE_WIDTH > MARGIN_WIDTH + 1) ? VALUE_WIDTH : MARGIN_WIDTH + 1;
  localparam int CmpW    = BaseW + 2;
  localparam int HoldW   = (TIME_WIDTH > HOLD_OFF_WIDTH) ? TIME_WIDTH : HOLD_OFF_WIDTH;

  // Configuration registers
  mode_e                    mode_q;
  logic [VALUE_WIDTH-1:0]   limit_low_q;
  logic [VALUE_WIDTH-1:0]   limit_high_q;
  logic [MARGIN_WIDTH-1:0]  margin_q;
  logic [HOLD_OFF_WIDTH-1:0] hold_off_q;
  logic [CfgExtW-1:0]       cfg_ext;

  // Input register
  logic                     s1_valid_q;
  logic [VALUE_WIDTH-1:0]   s1_sample_q;
  logic [TIME_WIDTH-1:0]    s1_time_q;

  // Trigger state
  trig_state_e              state_q, state_d;
  logic                     pending_q, pending_d;
  logic [TIME_WIDTH-1:0]    trig_time_q, trig_time_d;

  // Result register
  logic                     out_valid_q;
  trig_state_e              out_state_q;
  logic                     out_changed_q;

  // Datapath signals
  logic                     out_free;
  logic                     s1_adv;
  logic                     was_trig;
  logic signed [CmpW-1:0]   samp_x, lo_x, hi_x, margin_x;
  logic signed [CmpW-1:0]   lo_plus, lo_minus, hi_plus, hi_minus;
  logic                     cond;
  logic [TIME_WIDTH-1:0]    elapsed;
  logic                     hold_done;
  logic                     pending_live;
  logic                     rewrite;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;

  // Configuration writes; unknown indexes are ignored.
  assign cfg_ext = CfgExtW'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_BELOW;
      limit_low_q  <= '0;
      limit_high_q <= '0;
      margin_q     <= '0;
      hold_off_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:       mode_q       <= mode_e'(cfg_data_i[1:0]);
        CFG_LIMIT_LOW:  limit_low_q  <= cfg_ext[VALUE_WIDTH-1:0];
        CFG_LIMIT_HIGH: limit_high_q <= cfg_ext[VALUE_WIDTH-1:0];
        CFG_MARGIN:     margin_q     <= cfg_data_i[MARGIN_WIDTH-1:0];
        CFG_HOLD_OFF:   hold_off_q   <= cfg_data_i[HOLD_OFF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register: loads whenever it is empty or its item moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_sample_q <= sample_i;
      s1_time_q   <= time_ms_i;
    end
  end

  // Limits widened by the release margin while triggered, in a width that cannot overflow.
  assign was_trig = (state_q == ST_TRIG);
  assign samp_x   = CmpW'($signed(s1_sample_q));
  assign lo_x     = CmpW'($signed(limit_low_q));
  assign hi_x     = CmpW'($signed(limit_high_q));
  assign margin_x = was_trig ? CmpW'($signed({1'b0, margin_q})) : '0;
  assign lo_plus  = lo_x + margin_x;
  assign lo_minus = lo_x - margin_x;
  assign hi_plus  = hi_x + margin_x;
  assign hi_minus = hi_x - margin_x;

  // Trigger condition for the selected mode.
  always_comb begin
    case (mode_q)
      MODE_BELOW:   cond = (samp_x <= lo_plus);
      MODE_ABOVE:   cond = (samp_x >= lo_minus);
      MODE_INSIDE:  cond = (samp_x >= lo_minus) && (samp_x <= hi_plus);
      MODE_OUTSIDE: cond = (samp_x <= lo_plus) || (samp_x >= hi_minus);
      default:      cond = 1'b0;
    endcase
  end

  // Hold-off: elapsed time wraps at the timestamp width.
  assign elapsed      = s1_time_q - trig_time_q;
  assign hold_done    = HoldW'(elapsed) >= HoldW'(hold_off_q);
  assign pending_live = pending_q && !hold_done;

  // The state is rewritten on the first item, or on a change not blocked by the hold-off.
  assign rewrite = (state_q == ST_DISABLED) ||
                   ((cond != was_trig) && (cond || !pending_live));

  always_comb begin
    state_d     = state_q;
    pending_d   = pending_live;
    trig_time_d = trig_time_q;
    if (rewrite) begin
      state_d   = cond ? ST_TRIG : ST_IDLE;
      pending_d = cond && (hold_off_q != '0);
      if (cond && (hold_off_q != '0)) begin
        trig_time_d = s1_time_q;
      end
    end
  end

  // State update as the item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DISABLED;
      pending_q   <= 1'b0;
      trig_time_q <= '0;
    end else if (s1_adv) begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      trig_time_q <= trig_time_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_state_q   <= state_d;
      out_changed_q <= rewrite;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_state_o = out_state_q;
  assign changed_o       = out_changed_q;

  // Checks on the trigger logic.
  `TWT_ASSERT_SAME(a_result_not_disabled, out_valid_o, out_state_q != ST_DISABLED, "disabled result")
  `TWT_ASSERT_SAME(a_pending_only_triggered, pending_q, state_q == ST_TRIG, "stray hold-off")
  `TWT_ASSERT_NEXT(a_item_reaches_output, s1_adv, out_valid_q, "item lost before the output")
  `TWT_ASSERT_NEXT(a_first_changes, s1_adv && (state_q == ST_DISABLED), out_changed_q, "no change")

endmodule
